>>> sv/plpw_pkg.sv
// ----------------------------------------------------------------------------
// plpw_pkg
// Shared geometry, bus command codes and column/page wrap tables for the
// page-addressed LCD pixel writer.
// ----------------------------------------------------------------------------
`default_nettype none

package plpw_pkg;

    // Display geometry
    localparam int COLUMNS     = 128;   // 16 .. 128
    localparam int PAGES       = 8;     // 1 .. 8

    // Frame store: page-major, stride COLUMNS
    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Field widths
    localparam int COL_W  = 7;
    localparam int PAGE_W = 3;

    // Bus command codes
    localparam logic [7:0] CMD_COL_HIGH     = 8'h10;
    localparam logic [7:0] CMD_COL_LOW_MASK = 8'h0F;
    localparam logic [7:0] CMD_PAGE         = 8'hB0;
    localparam logic [7:0] ICON_PAGE        = 8'h08;

    // Bus address line values
    localparam logic BUS_CMD  = 1'b0;
    localparam logic BUS_DATA = 1'b1;

    typedef logic [COL_W-1:0]  col_table_t  [2**COL_W];
    typedef logic [PAGE_W-1:0] page_table_t [2**PAGE_W];

    // Column modulo COLUMNS, evaluated at elaboration
    function automatic col_table_t build_col_wrap();
        col_table_t t;
        for (int i = 0; i < 2**COL_W; i++)
        begin
            t[i] = COL_W'(i % COLUMNS);
        end
        return t;
    endfunction

    // Page modulo PAGES, evaluated at elaboration
    function automatic page_table_t build_page_wrap();
        page_table_t t;
        for (int i = 0; i < 2**PAGE_W; i++)
        begin
            t[i] = PAGE_W'(i % PAGES);
        end
        return t;
    endfunction

    localparam col_table_t  COL_WRAP  = build_col_wrap();
    localparam page_table_t PAGE_WRAP = build_page_wrap();

endpackage

`default_nettype wire

>>> sv/plpw_ram.sv
// ----------------------------------------------------------------------------
// plpw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module plpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/page_lcd_pixel_writer.sv
// ----------------------------------------------------------------------------
// page_lcd_pixel_writer
// Frame store and bus writer for a page-addressed monochrome LCD.
// ----------------------------------------------------------------------------
// Each accepted request produces exactly four output transfers: column high
// command, column low command, page command and the data byte (last_write
// marks the fourth). The next request is taken at the same edge as the final
// transfer of the previous one; the request rate is set by the single output
// register that serialises the four bus writes. Pixel requests read the frame
// store byte in the accept cycle, patch the bit and write it back in the
// following cycle, well before the next request can be taken, so no
// forwarding is needed. After reset the frame store is cleared by a pass over
// all 1024 bytes, one byte per cycle, during which in_stall is held high.
// Glyph requests never touch the store.
// ----------------------------------------------------------------------------
`default_nettype none

module page_lcd_pixel_writer
    import plpw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic        pixel_value,
    input  wire logic [6:0]  x_column,
    input  wire logic [5:0]  y_row,
    input  wire logic [7:0]  glyph_byte,

    // bus write channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             bus_address,
    output logic [7:0]       bus_byte,
    output logic             last_write
);

    // Which of the four bus writes is on the output
    typedef enum logic [1:0] {
        SLOT_COL_HIGH,
        SLOT_COL_LOW,
        SLOT_PAGE,
        SLOT_DATA
    } slot_t;

    // ------------------------------------------------------------------
    // Clearing pass state
    // ------------------------------------------------------------------
    logic                clear_reg, clear_next;
    logic [STORE_AW-1:0] clr_addr_reg, clr_addr_next;

    // ------------------------------------------------------------------
    // Request context
    // ------------------------------------------------------------------
    logic [COL_W-1:0]    flipped_reg;     // COLUMNS-1-col
    logic [7:0]          page_cmd_reg;    // full page command byte
    logic [7:0]          data_reg;        // data byte for the final write
    logic                pix_reg;
    logic [2:0]          bit_pos_reg;     // bit 7-(row mod 8)
    logic [STORE_AW-1:0] wb_addr_reg;
    logic                wb_pending_reg, wb_pending_next;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                out_valid_reg, out_valid_next;
    logic                bus_address_reg, bus_address_next;
    logic [7:0]          bus_byte_reg, bus_byte_next;
    logic                last_write_reg, last_write_next;
    slot_t               slot_reg, slot_next;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_xfer;
    logic out_xfer;

    // Hold off requests while clearing, or while a burst is still being
    // moved unless its final transfer completes this cycle.
    assign in_stall = clear_reg
                   || (out_valid_reg && !(!out_stall && last_write_reg));
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic [COL_W-1:0]    col_w;
    logic [PAGE_W-1:0]   page_w;
    logic [COL_W-1:0]    flipped_w;
    logic [STORE_AW-1:0] idx_w;
    logic [7:0]          page_cmd_w;

    assign col_w      = COL_WRAP[x_column];
    assign page_w     = PAGE_WRAP[y_row[5:3]];
    assign flipped_w  = COL_W'(COLUMNS - 1) - col_w;
    assign idx_w      = STORE_AW'(page_w * COLUMNS) + STORE_AW'(col_w);
    assign page_cmd_w = req_type ? (CMD_PAGE | ICON_PAGE)
                                 : (CMD_PAGE | 8'(PAGE_W'(PAGES - 1) - page_w));

    // ------------------------------------------------------------------
    // Frame store
    // ------------------------------------------------------------------
    logic                ram_wr_en;
    logic [STORE_AW-1:0] ram_wr_addr;
    logic [7:0]          ram_wr_data;
    logic                ram_rd_en;
    logic [7:0]          ram_rd_data;
    logic [7:0]          bit_mask;
    logic [7:0]          mod_byte;

    // Patch the addressed bit of the byte read in the accept cycle
    assign bit_mask = 8'h01 << bit_pos_reg;
    assign mod_byte = (ram_rd_data & ~bit_mask) | (pix_reg ? bit_mask : 8'h00);

    assign ram_rd_en   = in_xfer && !req_type;
    assign ram_wr_en   = clear_reg || wb_pending_reg;
    assign ram_wr_addr = clear_reg ? clr_addr_reg : wb_addr_reg;
    assign ram_wr_data = clear_reg ? 8'h00 : mod_byte;

    plpw_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_w),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        clear_next       = clear_reg;
        clr_addr_next    = clr_addr_reg;
        wb_pending_next  = in_xfer && !req_type;
        out_valid_next   = out_valid_reg;
        bus_address_next = bus_address_reg;
        bus_byte_next    = bus_byte_reg;
        last_write_next  = last_write_reg;
        slot_next        = slot_reg;

        // Advance the clearing pass one byte per cycle
        if (clear_reg)
        begin
            clr_addr_next = clr_addr_reg + STORE_AW'(1);
            if (clr_addr_reg == STORE_AW'(STORE_DEPTH - 1))
            begin
                clear_next = 1'b0;
            end
        end

        if (in_xfer)
        begin
            // Load the column high command straight away
            out_valid_next   = 1'b1;
            slot_next        = SLOT_COL_HIGH;
            bus_address_next = BUS_CMD;
            bus_byte_next    = CMD_COL_HIGH | 8'(flipped_w >> 4);
            last_write_next  = 1'b0;
        end
        else if (out_xfer)
        begin
            unique case (slot_reg)
                SLOT_COL_HIGH:
                begin
                    slot_next        = SLOT_COL_LOW;
                    bus_address_next = BUS_CMD;
                    bus_byte_next    = CMD_COL_LOW_MASK & 8'(flipped_reg);
                    last_write_next  = 1'b0;
                end
                SLOT_COL_LOW:
                begin
                    slot_next        = SLOT_PAGE;
                    bus_address_next = BUS_CMD;
                    bus_byte_next    = page_cmd_reg;
                    last_write_next  = 1'b0;
                end
                SLOT_PAGE:
                begin
                    slot_next        = SLOT_DATA;
                    bus_address_next = BUS_DATA;
                    bus_byte_next    = data_reg;
                    last_write_next  = 1'b1;
                end
                SLOT_DATA:
                begin
                    // Burst done: drop the output
                    out_valid_next   = 1'b0;
                    last_write_next  = 1'b0;
                end
                default:
                begin
                    out_valid_next   = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and output registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg       <= 1'b1;
            clr_addr_reg    <= '0;
            wb_pending_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            bus_address_reg <= BUS_CMD;
            bus_byte_reg    <= 8'h00;
            last_write_reg  <= 1'b0;
            slot_reg        <= SLOT_COL_HIGH;
        end
        else
        begin
            clear_reg       <= clear_next;
            clr_addr_reg    <= clr_addr_next;
            wb_pending_reg  <= wb_pending_next;
            out_valid_reg   <= out_valid_next;
            bus_address_reg <= bus_address_next;
            bus_byte_reg    <= bus_byte_next;
            last_write_reg  <= last_write_next;
            slot_reg        <= slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Request context registers (payload, no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            flipped_reg  <= flipped_w;
            page_cmd_reg <= page_cmd_w;
            pix_reg      <= pixel_value;
            bit_pos_reg  <= 3'd7 - y_row[2:0];
            wb_addr_reg  <= idx_w;
            if (req_type)
            begin
                data_reg <= glyph_byte;
            end
        end
        // Capture the patched byte as it is written back
        if (wb_pending_reg)
        begin
            data_reg <= mod_byte;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bus_address = bus_address_reg;
    assign bus_byte    = bus_byte_reg;
    assign last_write  = last_write_reg;

endmodule

`default_nettype wire

>>> sv/plpw_checker.sv
// ----------------------------------------------------------------------------
// plpw_checker
// Port-level checks on the LCD pixel writer: burst shape and request flow.
// ----------------------------------------------------------------------------
`default_nettype none

module plpw_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        bus_address,
    input  wire logic [7:0]  bus_byte,
    input  wire logic        last_write
);

    // A request shows its first bus write in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
    else $error("no bus write after accepted request");

    // A burst runs without gaps until its final write
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_write) |=> out_valid)
    else $error("gap inside a bus write burst");

    // No request is taken in the middle of a burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_write) |-> in_stall)
    else $error("request taken mid-burst");

    // A stalled bus write holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(bus_byte) && $stable(bus_address)
             && $stable(last_write)))
    else $error("stalled bus write changed");

endmodule

bind page_lcd_pixel_writer plpw_checker u_plpw_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page-addressed LCD pixel writer: drives pixel
// and glyph requests with bursty valid and patterned output stalls, keeps a
// shadow frame store and checks every bus write transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import plpw_pkg::*;

    // Request kinds on req_type
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_GLYPH = 1'b1;

    // Run length and pressure settings
    localparam int RANDOM_REQUESTS = 450;
    localparam int DRAIN_AT        = 300;      // random request index of the mid-run drain
    localparam int HOLDOFF_AT      = 150;      // accepted requests before the long hold-off
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int SETTLE_CYCLES   = 16;       // quiet time after the last transfer
    localparam int CYCLE_LIMIT     = 200000;   // clear pass plus worst case stalls, many times over
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        logic       addr;
        logic [7:0] data;
        logic       last;
    } bus_write_t;

    // ------------------------------------------------------------------------
    // Shadow frame store and queue of predicted bus writes.
    // ------------------------------------------------------------------------
    class bus_write_book;
        bus_write_t pending_writes[$];
        logic [7:0] shadow_frame [STORE_DEPTH];
        int         failures;

        function new();
            foreach (shadow_frame[i])
                shadow_frame[i] = 8'h00;
            failures = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void queue_write(logic a, logic [7:0] d, logic l);
            bus_write_t w;
            w.addr = a;
            w.data = d;
            w.last = l;
            pending_writes.push_back(w);
        endfunction

        // Predict the four bus writes of one accepted request and, for a pixel request, update the store.
        function void take_request(logic rt, logic pv, logic [6:0] x, logic [5:0] y,
                                   logic [7:0] g);
            int unsigned col;
            int unsigned flipped;
            int unsigned page;
            int unsigned sh;
            int unsigned idx;
            logic [7:0]  pix_byte;
            col     = x % COLUMNS;
            flipped = (COLUMNS - 1 - col) & 'h7F;
            queue_write(BUS_CMD, CMD_COL_HIGH | 8'(flipped >> 4), 1'b0);
            queue_write(BUS_CMD, CMD_COL_LOW_MASK & 8'(flipped), 1'b0);
            if (rt == REQ_GLYPH)
            begin
                queue_write(BUS_CMD, CMD_PAGE | ICON_PAGE, 1'b0);
                queue_write(BUS_DATA, g, 1'b1);
            end
            else
            begin
                page     = (y >> 3) % PAGES;
                sh       = 7 - (y & 7);
                idx      = (page * COLUMNS + col) % STORE_DEPTH;
                pix_byte = shadow_frame[idx];
                pix_byte[sh] = pv;
                shadow_frame[idx] = pix_byte;
                queue_write(BUS_CMD, CMD_PAGE | 8'((PAGES - 1 - page) & 'hF), 1'b0);
                queue_write(BUS_DATA, pix_byte, 1'b1);
            end
        endfunction

        function void check_write(logic a, logic [7:0] d, logic l);
            bus_write_t w;
            if (pending_writes.size() == 0)
            begin
                note_failure($sformatf("unexpected bus write addr=%0b byte=%02h last=%0b",
                                       a, d, l));
                return;
            end
            w = pending_writes.pop_front();
            if (a !== w.addr || d !== w.data || l !== w.last)
                note_failure($sformatf(
                    "expected addr=%0b byte=%02h last=%0b, got addr=%0b byte=%02h last=%0b",
                    w.addr, w.data, w.last, a, d, l));
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals. Hold every input at a known value from
    // time zero.
    // ------------------------------------------------------------------------
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       req_type    = 1'b0;
    logic       pixel_value = 1'b0;
    logic [6:0] x_column    = '0;
    logic [5:0] y_row       = '0;
    logic [7:0] glyph_byte  = '0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic       bus_address;
    logic [7:0] bus_byte;
    logic       last_write;

    bus_write_book book = new();
    int            requests_in = 0;
    int            cycle_count = 0;
    bit            holdoff_done = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    page_lcd_pixel_writer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .pixel_value (pixel_value),
        .x_column    (x_column),
        .y_row       (y_row),
        .glyph_byte  (glyph_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bus_address (bus_address),
        .bus_byte    (bus_byte),
        .last_write  (last_write)
    );

    // ------------------------------------------------------------------------
    // Monitors. All stimulus changes by nonblocking assignment at the edge, so
    // sampling here sees the values that were present at the edge itself.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Predict from each accepted request transfer
            if (in_valid && !in_stall)
            begin
                book.take_request(req_type, pixel_value, x_column, y_row, glyph_byte);
                requests_in++;
            end
            // Check each accepted bus write transfer against the oldest prediction
            if (out_valid && !out_stall)
                book.check_write(bus_address, bus_byte, last_write);
        end
    end

    // Watchdog: fail the run once cycle_count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** page_lcd_pixel_writer: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on patterns of its own choosing, each for a random span.
    // Once enough requests are in, hold off for a long stretch so the block
    // fills and pushes back on its input while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int span;
        int k;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!holdoff_done && requests_in >= HOLDOFF_AT)
            begin
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                holdoff_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (k = 0; k < span; k++)
            begin
                case (mode)
                    0:       out_stall <= 1'b0;                          // stretch with no stall
                    1:       out_stall <= ($urandom_range(0, 1) == 1);   // heavy random stall
                    2:       out_stall <= (k % 3 == 0);                  // periodic stall on k % 3
                    default: out_stall <= ($urandom_range(0, 7) == 0);   // light random stall
                endcase
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one request and hold it until the transfer completes.
    task automatic send_request(input logic rt, input logic pv, input logic [6:0] x,
                                input logic [5:0] y, input logic [7:0] g);
        in_valid    <= 1'b1;
        req_type    <= rt;
        pixel_value <= pv;
        x_column    <= x;
        y_row       <= y;
        glyph_byte  <= g;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid for a number of cycles; zero leaves valid high for the next request.
    task automatic sender_gap(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Pause the sender until every predicted bus write has arrived. Step to the
    // next edge first so the monitor has booked the request accepted at this edge.
    task automatic drain_writes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // Half are pixel requests on eight hot columns, so those bytes are patched many
    // times; the rest are pixels anywhere and glyph writes.
    task automatic send_random_request();
        int         pick;
        logic       rt;
        logic       pv;
        logic [6:0] x;
        logic [5:0] y;
        logic [7:0] g;
        pick = $urandom_range(0, 9);
        pv   = 1'($urandom_range(0, 1));
        x    = 7'($urandom_range(0, 127));
        y    = 6'($urandom_range(0, 63));
        g    = 8'($urandom_range(0, 255));
        if (pick < 5)
        begin
            rt = REQ_PIXEL;
            x  = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 3))
                                             : 7'($urandom_range(124, 127));
        end
        else if (pick < 8)
            rt = REQ_PIXEL;
        else
            rt = REQ_GLYPH;
        send_request(rt, pv, x, y, g);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int sent;
        int burst;
        int r;

        // Hold reset, then release it; the block then clears its store with in_stall high.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners of the frame, bits of one byte, clearing a set bit,
        // glyphs at both column extremes, and ignored fields at their extremes.
        send_request(REQ_PIXEL, 1'b1, 7'd0,   6'd0,  8'h00);
        send_request(REQ_PIXEL, 1'b1, 7'd0,   6'd7,  8'hFF);
        send_request(REQ_PIXEL, 1'b1, 7'd127, 6'd63, 8'hFF);
        send_request(REQ_PIXEL, 1'b1, 7'd127, 6'd56, 8'h00);
        send_request(REQ_PIXEL, 1'b0, 7'd0,   6'd0,  8'hFF);
        send_request(REQ_GLYPH, 1'b1, 7'd0,   6'd63, 8'h00);
        send_request(REQ_GLYPH, 1'b0, 7'd127, 6'd0,  8'hFF);
        send_request(REQ_GLYPH, 1'b1, 7'd85,  6'd42, 8'hA5);
        sender_gap(5);
        send_request(REQ_PIXEL, 1'b1, 7'd64,  6'd32, 8'hFF);
        send_request(REQ_PIXEL, 1'b0, 7'd64,  6'd32, 8'h00);
        send_request(REQ_PIXEL, 1'b1, 7'd63,  6'd31, 8'h5A);
        // Fill one byte row by row, then clear a middle bit
        for (r = 0; r < 8; r++)
            send_request(REQ_PIXEL, 1'b1, 7'd5, 6'(8 + r), 8'h00);
        send_request(REQ_PIXEL, 1'b0, 7'd5, 6'd11, 8'hFF);
        send_request(REQ_GLYPH, 1'b0, 7'd5, 6'd11, 8'h3C);

        // Let everything drain before the random part.
        drain_writes();

        // Random: bursts of random length with random gaps, sometimes back to back.
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < RANDOM_REQUESTS)
            begin
                send_random_request();
                sent++;
                burst--;
                if (sent == DRAIN_AT)
                    drain_writes();
            end
            if ($urandom_range(0, 3) == 0)
                sender_gap(0);
            else
                sender_gap($urandom_range(1, 15));
        end

        // Wait for every predicted write, then a quiet stretch for strays.
        drain_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (book.pending() != 0)
            book.note_failure($sformatf("%0d bus writes never arrived", book.pending()));

        if (book.failures == 0)
            $display("** page_lcd_pixel_writer: PASSED **");
        else
            $display("** page_lcd_pixel_writer: FAILED **");
        $finish;
    end

endmodule
